FILE: src/assert_macros.svh
// Assertion macros shared by the descrambler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define LFD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define LFD_NEVER(label, clk, rst, cond, msg) \
  `LFD_ASSERT(label, clk, rst, !(cond), msg)

`endif

FILE: src/lfd_pkg.sv
// Types, constants and keystream functions for the frame descrambler.
package lfd_pkg;

  localparam int MAX_BYTES   = 256;
  localparam int COUNT_W     = $clog2(MAX_BYTES + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] KEY_FIRST_RESET  = 32'hDFD109E8;
  localparam logic [31:0] KEY_SECOND_RESET = 32'hB71F0AE8;
  localparam logic [7:0]  CHECK_RESET      = 8'h4B;

  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_DATA   = 1'b1;

  localparam logic STATUS_KEY_FOUND   = 1'b0;
  localparam logic STATUS_KEY_UNKNOWN = 1'b1;

  localparam logic KEY_SEL_FIRST  = 1'b0;
  localparam logic KEY_SEL_SECOND = 1'b1;

  typedef enum logic [1:0] {
    REG_KEY_FIRST   = 2'd0,
    REG_KEY_SECOND  = 2'd1,
    REG_CHECK_VALUE = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic        op;
    logic [7:0]  enc_byte;
    logic        last_in;
    logic [15:0] manufacturer;
    logic [31:0] meter_id;
    logic [7:0]  version_code;
    logic [7:0]  medium_code;
    logic [7:0]  ci_field;
    logic [7:0]  apdu_first;
    logic [7:0]  apdu_second;
    logic [7:0]  apdu_third;
  } in_item_t;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       status;
    logic       key_index;
    logic       last_out;
  } out_item_t;

  // Classified work item handed from the front to the back.
  typedef struct packed {
    logic        is_header;
    logic        first;
    logic        last;
    logic [7:0]  enc_byte;
    logic [31:0] mix;
  } cmd_t;

  typedef struct packed {
    logic [31:0] key_first;
    logic [31:0] key_second;
    logic [7:0]  check_value;
  } cfg_t;

  // Eight Fibonacci steps: shift left, feedback from bits 1, 2, 11 and 31.
  function automatic logic [31:0] clock_byte(input logic [31:0] r);
    logic [31:0] s;
    s = r;
    for (int i = 0; i < 8; i++) begin
      s = {s[30:0], s[1] ^ s[2] ^ s[11] ^ s[31]};
    end
    return s;
  endfunction

  // Header fields folded into one word, ready to XOR with a key.
  function automatic logic [31:0] seed_mix(input in_item_t it);
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    w0 = {it.manufacturer[7:0], it.manufacturer[15:8], it.meter_id[7:0], it.meter_id[15:8]};
    w1 = {it.meter_id[23:16], it.meter_id[31:24], it.version_code, it.medium_code};
    w2 = {it.ci_field, it.apdu_first, it.apdu_second, it.apdu_third};
    return w0 ^ w1 ^ w2;
  endfunction

endpackage

FILE: src/lfd_front.sv
// Front end: classifies input items, folds headers, limits bytes per frame.
module lfd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  lfd_pkg::in_item_t item,
  output logic             cmd_push,
  output lfd_pkg::cmd_t    cmd
);
  import lfd_pkg::*;

  logic [COUNT_W-1:0] byte_count;
  logic [COUNT_W-1:0] byte_count_next;
  logic               is_header;
  logic               room;

  assign is_header = (item.op == OP_HEADER);
  assign room      = (byte_count < COUNT_W'(MAX_BYTES));

  always_comb begin
    byte_count_next = byte_count;
    if (accept) begin
      if (is_header) begin
        byte_count_next = '0;
      end else if (room) begin
        byte_count_next = byte_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else begin
      byte_count <= byte_count_next;
    end
  end

  // Drop data bytes past the frame limit here, so the back never sees them.
  assign cmd_push      = accept && (is_header || room);
  assign cmd.is_header = is_header;
  assign cmd.first     = (byte_count == '0);
  assign cmd.last      = item.last_in;
  assign cmd.enc_byte  = item.enc_byte;
  assign cmd.mix       = seed_mix(item);

endmodule

FILE: src/lfd_cmd_fifo.sv
// Short queue of classified work items between front and back.
module lfd_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lfd_pkg::cmd_t cmd_in,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output lfd_pkg::cmd_t cmd_out
);
  import lfd_pkg::*;
  `include "assert_macros.svh"

  cmd_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign cmd_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `LFD_NEVER(a_cmd_overflow, clk, rst, push && full, "work item pushed into full queue")
  `LFD_ASSERT(a_cmd_drain, clk, rst, (pop && !empty && !push) |=> (count == $past(count) - 1'b1), "queue count did not drop on transfer out")

endmodule

FILE: src/lfd_back.sv
// Back end: runs both keystreams, picks the key, queues results.
module lfd_back (
  input  logic              clk,
  input  logic              rst,
  input  lfd_pkg::cfg_t     cfg,
  input  logic              cmd_empty,
  input  lfd_pkg::cmd_t     cmd,
  output logic              cmd_pop,
  input  logic              pop,
  output logic              empty,
  output lfd_pkg::out_item_t result
);
  import lfd_pkg::*;
  `include "assert_macros.svh"

  logic [31:0]      lfsr_first;
  logic [31:0]      lfsr_second;
  logic             chosen_key;
  logic             frame_failed;

  out_item_t        res_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] res_wr_ptr;
  logic [PTR_W-1:0] res_rd_ptr;
  logic [CNT_W-1:0] res_count;

  logic [31:0]      lfsr_first_next;
  logic [31:0]      lfsr_second_next;
  logic [7:0]       d1;
  logic [7:0]       d2;
  logic             key_sel;
  logic             fail_sel;
  logic             res_space;
  logic             take;
  logic             res_push;
  logic             res_pop;
  out_item_t        res_new;

  assign lfsr_first_next  = clock_byte(lfsr_first);
  assign lfsr_second_next = clock_byte(lfsr_second);
  assign d1 = cmd.enc_byte ^ lfsr_first_next[7:0];
  assign d2 = cmd.enc_byte ^ lfsr_second_next[7:0];

  // First byte of a frame decides the key; first key wins a tie.
  always_comb begin
    key_sel  = chosen_key;
    fail_sel = frame_failed;
    if (cmd.first) begin
      priority if (d1 == cfg.check_value) begin
        key_sel  = KEY_SEL_FIRST;
        fail_sel = 1'b0;
      end else if (d2 == cfg.check_value) begin
        key_sel  = KEY_SEL_SECOND;
        fail_sel = 1'b0;
      end else begin
        key_sel  = KEY_SEL_FIRST;
        fail_sel = 1'b1;
      end
    end
  end

  always_comb begin
    res_new.last_out = cmd.last;
    if (fail_sel) begin
      res_new.plain_byte = '0;
      res_new.status     = STATUS_KEY_UNKNOWN;
      res_new.key_index  = KEY_SEL_FIRST;
    end else begin
      res_new.plain_byte = (key_sel == KEY_SEL_SECOND) ? d2 : d1;
      res_new.status     = STATUS_KEY_FOUND;
      res_new.key_index  = key_sel;
    end
  end

  assign empty     = (res_count == '0);
  assign result    = res_mem[res_rd_ptr];
  assign res_pop   = pop && !empty;
  assign res_space = (res_count != CNT_W'(QUEUE_DEPTH)) || res_pop;
  // Headers never wait on the result queue.
  assign take      = !cmd_empty && (cmd.is_header || res_space);
  assign res_push  = take && !cmd.is_header;
  assign cmd_pop   = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr_first   <= '0;
      lfsr_second  <= '0;
      chosen_key   <= KEY_SEL_FIRST;
      frame_failed <= 1'b0;
    end else if (take) begin
      if (cmd.is_header) begin
        lfsr_first   <= cfg.key_first ^ cmd.mix;
        lfsr_second  <= cfg.key_second ^ cmd.mix;
        chosen_key   <= KEY_SEL_FIRST;
        frame_failed <= 1'b0;
      end else begin
        lfsr_first   <= lfsr_first_next;
        lfsr_second  <= lfsr_second_next;
        chosen_key   <= key_sel;
        frame_failed <= fail_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_mem[res_wr_ptr] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr_ptr <= '0;
      res_rd_ptr <= '0;
      res_count  <= '0;
    end else begin
      if (res_push) res_wr_ptr <= res_wr_ptr + 1'b1;
      if (res_pop)  res_rd_ptr <= res_rd_ptr + 1'b1;
      if (res_push && !res_pop) begin
        res_count <= res_count + 1'b1;
      end else if (res_pop && !res_push) begin
        res_count <= res_count - 1'b1;
      end
    end
  end

  `LFD_NEVER(a_res_overflow, clk, rst, res_push && (res_count == CNT_W'(QUEUE_DEPTH)) && !res_pop, "result pushed into full queue")
  `LFD_ASSERT(a_header_clears, clk, rst, (take && cmd.is_header) |=> (!frame_failed && !chosen_key), "header did not clear key choice")
  `LFD_NEVER(a_header_no_result, clk, rst, res_push && cmd.is_header, "header produced a result")

endmodule

FILE: src/lfsr_frame_descrambler_core.sv
// Top level of the frame descrambler: configuration registers and the front/back pipeline.
//
// Takes one item per clock on the push/full side while full is low, and hands out one result per
// data byte on the empty/pop side; headers give no result and data bytes past the frame limit are
// dropped. A data byte waits in the work queue until the result queue has room; the back end then
// runs both eight-step keystream shifts combinationally and writes the result queue. Full rises
// only when the two-entry result queue is left unread and the two-entry work queue behind it fills
// up. Key and check registers are written through wr_en/wr_index/wr_data; the keys take effect on
// the next header and the check value on the next first byte of a frame; write them only while
// the block is idle.
module lfsr_frame_descrambler_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  lfd_pkg::in_item_t  item,
  input  logic               pop,
  output logic               empty,
  output lfd_pkg::out_item_t result,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [31:0]        wr_data
);
  import lfd_pkg::*;

  cfg_t cfg;
  logic accept;
  logic cmd_push;
  cmd_t cmd_front;
  logic cmd_pop;
  logic cmd_empty;
  cmd_t cmd_back;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_first   <= KEY_FIRST_RESET;
      cfg.key_second  <= KEY_SECOND_RESET;
      cfg.check_value <= CHECK_RESET;
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_KEY_FIRST:   cfg.key_first   <= wr_data;
        REG_KEY_SECOND:  cfg.key_second  <= wr_data;
        REG_CHECK_VALUE: cfg.check_value <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  lfd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .cmd_push (cmd_push),
    .cmd      (cmd_front)
  );

  lfd_cmd_fifo u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd_push),
    .cmd_in  (cmd_front),
    .pop     (cmd_pop),
    .full    (full),
    .empty   (cmd_empty),
    .cmd_out (cmd_back)
  );

  lfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_back),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

endmodule

FILE: tb/lfd_descrambler_checker.sv
// Checker for the frame descrambler: mirrors config writes, predicts results, compares.
`timescale 1ns / 100ps

module lfd_descrambler_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  lfd_pkg::in_item_t  item,
  input  logic               pop,
  input  logic               empty,
  input  lfd_pkg::out_item_t result,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [31:0]        wr_data,
  output int unsigned        mismatches,
  output int unsigned        pending,
  output int unsigned        checked
);
  import lfd_pkg::*;

  logic [31:0] key_a;
  logic [31:0] key_b;
  logic [7:0]  check_byte;
  logic [31:0] ks_first;
  logic [31:0] ks_second;
  int unsigned frame_bytes;
  logic        key_sel;
  logic        key_missing;
  int unsigned fail_total;
  int unsigned good_total;
  out_item_t   decoded_q[$];

  // Eight register shifts; the XOR of bits 1, 2, 11 and 31 enters at bit 0.
  function automatic logic [31:0] shift8(input logic [31:0] r);
    logic [31:0] s;
    s = r;
    for (int i = 0; i < 8; i++) begin
      s = {s[30:0], s[1] ^ s[2] ^ s[11] ^ s[31]};
    end
    return s;
  endfunction

  always @(posedge clk) begin
    logic [31:0] fold;
    logic [7:0]  d_first;
    logic [7:0]  d_second;
    out_item_t   want;
    if (rst) begin
      key_a       = KEY_FIRST_RESET;
      key_b       = KEY_SECOND_RESET;
      check_byte  = CHECK_RESET;
      ks_first    = '0;
      ks_second   = '0;
      frame_bytes = 0;
      key_sel     = KEY_SEL_FIRST;
      key_missing = 1'b0;
      fail_total  = 0;
      good_total  = 0;
      decoded_q.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_KEY_FIRST:   key_a = wr_data;
          REG_KEY_SECOND:  key_b = wr_data;
          REG_CHECK_VALUE: check_byte = wr_data[7:0];
          default: ;
        endcase
      end

      if (push && !full) begin
        if (item.op == OP_HEADER) begin
          fold = {item.manufacturer[7:0], item.manufacturer[15:8],
                  item.meter_id[7:0], item.meter_id[15:8]}
               ^ {item.meter_id[23:16], item.meter_id[31:24],
                  item.version_code, item.medium_code}
               ^ {item.ci_field, item.apdu_first, item.apdu_second, item.apdu_third};
          ks_first    = key_a ^ fold;
          ks_second   = key_b ^ fold;
          frame_bytes = 0;
          key_sel     = KEY_SEL_FIRST;
          key_missing = 1'b0;
        end else if (frame_bytes < MAX_BYTES) begin
          ks_first  = shift8(ks_first);
          ks_second = shift8(ks_second);
          d_first   = item.enc_byte ^ ks_first[7:0];
          d_second  = item.enc_byte ^ ks_second[7:0];
          // The first byte of a frame decides the key for the whole frame.
          if (frame_bytes == 0) begin
            key_missing = 1'b0;
            if (d_first == check_byte) begin
              key_sel = KEY_SEL_FIRST;
            end else if (d_second == check_byte) begin
              key_sel = KEY_SEL_SECOND;
            end else begin
              key_sel     = KEY_SEL_FIRST;
              key_missing = 1'b1;
            end
          end
          frame_bytes++;
          if (key_missing) begin
            want.plain_byte = 8'h00;
            want.status     = STATUS_KEY_UNKNOWN;
            want.key_index  = KEY_SEL_FIRST;
          end else begin
            want.plain_byte = (key_sel == KEY_SEL_SECOND) ? d_second : d_first;
            want.status     = STATUS_KEY_FOUND;
            want.key_index  = key_sel;
          end
          want.last_out = item.last_in;
          decoded_q.push_back(want);
        end
      end

      if (pop && !empty) begin
        if (decoded_q.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("%0t: unexpected result plain=%02h status=%0d key=%0d last=%0d",
                     $time, result.plain_byte, result.status, result.key_index,
                     result.last_out);
        end else begin
          want = decoded_q.pop_front();
          good_total++;
          if (result.plain_byte !== want.plain_byte || result.status !== want.status ||
              result.key_index !== want.key_index || result.last_out !== want.last_out) begin
            fail_total++;
            if (fail_total <= 10)
              $display({"%0t: mismatch expected plain=%02h status=%0d key=%0d last=%0d,",
                        " got plain=%02h status=%0d key=%0d last=%0d"},
                       $time, want.plain_byte, want.status, want.key_index, want.last_out,
                       result.plain_byte, result.status, result.key_index, result.last_out);
          end
        end
      end
    end
    mismatches <= fail_total;
    checked    <= good_total;
    pending    <= decoded_q.size();
  end

endmodule

FILE: tb/tb_lfsr_frame_descrambler_core.sv
// Stimulus and verdict for the frame descrambler core.
`timescale 1ns / 100ps

module tb_lfsr_frame_descrambler_core;
  import lfd_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    PICK_FIRST,
    PICK_SECOND,
    PICK_NONE
  } key_pick_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  in_item_t    item = '0;
  logic        pop = 1'b0;
  logic        empty;
  out_item_t   result;
  logic        wr_en = 1'b0;
  logic [1:0]  wr_index = '0;
  logic [31:0] wr_data = '0;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned items_sent = 0;
  logic        calm = 1'b0;

  logic [31:0] cfg_key_first  = KEY_FIRST_RESET;
  logic [31:0] cfg_key_second = KEY_SECOND_RESET;
  logic [7:0]  cfg_check      = CHECK_RESET;

  lfsr_frame_descrambler_core u_top (
    .clk, .rst, .push, .full, .item, .pop, .empty, .result, .wr_en, .wr_index, .wr_data
  );

  lfd_descrambler_checker u_checker (
    .clk, .rst, .push, .full, .item, .pop, .empty, .result, .wr_en, .wr_index, .wr_data,
    .mismatches, .pending, .checked
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else     pop <= calm || ($urandom_range(99) >= 11);
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic in_item_t random_item();
    logic [127:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    return bits[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t data_item(input logic [7:0] enc, input logic last);
    in_item_t it;
    it          = random_item();
    it.op       = OP_DATA;
    it.enc_byte = enc;
    it.last_in  = last;
    return it;
  endfunction

  // Low keystream byte after the first eight shifts of a frame, used to hit the check byte.
  function automatic logic [7:0] first_keystream(input logic [31:0] key, input in_item_t hdr);
    logic [31:0] s;
    s = key
      ^ {hdr.manufacturer[7:0], hdr.manufacturer[15:8], hdr.meter_id[7:0], hdr.meter_id[15:8]}
      ^ {hdr.meter_id[23:16], hdr.meter_id[31:24], hdr.version_code, hdr.medium_code}
      ^ {hdr.ci_field, hdr.apdu_first, hdr.apdu_second, hdr.apdu_third};
    for (int i = 0; i < 8; i++) begin
      s = {s[30:0], s[1] ^ s[2] ^ s[11] ^ s[31]};
    end
    return s[7:0];
  endfunction

  task automatic send_item(input in_item_t it);
    while (!calm && $urandom_range(99) < 11) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  task automatic send_frame(input in_item_t hdr, input int unsigned nbytes,
                            input key_pick_t pick);
    logic [7:0] hit_first;
    logic [7:0] hit_second;
    in_item_t   d;
    hdr.op     = OP_HEADER;
    hit_first  = cfg_check ^ first_keystream(cfg_key_first, hdr);
    hit_second = cfg_check ^ first_keystream(cfg_key_second, hdr);
    send_item(hdr);
    for (int unsigned i = 0; i < nbytes; i++) begin
      d = data_item(8'($urandom_range(255)), i == nbytes - 1);
      if (i == 0) begin
        if (pick == PICK_FIRST) begin
          d.enc_byte = hit_first;
        end else if (pick == PICK_SECOND) begin
          d.enc_byte = hit_second;
        end else begin
          while (d.enc_byte == hit_first || d.enc_byte == hit_second)
            d.enc_byte = 8'($urandom_range(255));
        end
      end
      send_item(d);
    end
  endtask

  // Hold off until every expected transfer is out, then let headers and drops settle.
  task automatic drain();
    int unsigned waited;
    push <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < 5000);
    repeat (6) @(posedge clk);
  endtask

  task automatic program_regs(input logic [31:0] k1, input logic [31:0] k2,
                              input logic [7:0] chk);
    wr_en    <= 1'b1;
    wr_index <= REG_KEY_FIRST;
    wr_data  <= k1;
    @(posedge clk);
    wr_index <= REG_KEY_SECOND;
    wr_data  <= k2;
    @(posedge clk);
    wr_index <= REG_CHECK_VALUE;
    wr_data  <= {24'($urandom_range(24'hFFFFFF)), chk};
    @(posedge clk);
    // Index with no register behind it: must change nothing.
    wr_index <= REG_UNUSED;
    wr_data  <= $urandom;
    @(posedge clk);
    wr_en <= 1'b0;
    cfg_key_first  = k1;
    cfg_key_second = k2;
    cfg_check      = chk;
  endtask

  task automatic run_random(input int unsigned quota);
    int unsigned start;
    int unsigned p;
    key_pick_t   pick;
    start = items_sent;
    while (items_sent - start < quota) begin
      p = $urandom_range(99);
      if (p < 75) begin
        p    = $urandom_range(99);
        pick = (p < 45) ? PICK_FIRST : (p < 75) ? PICK_SECOND : PICK_NONE;
        send_frame(random_item(), $urandom_range(1, 10), pick);
      end else if (p < 85) begin
        // Stray bytes continue whatever frame is open.
        repeat ($urandom_range(1, 3))
          send_item(data_item(8'($urandom_range(255)), 1'($urandom)));
      end else if (p < 92) begin
        send_frame(random_item(), 0, PICK_NONE);
      end else begin
        send_frame(random_item(), $urandom_range(1, 4), PICK_NONE);
      end
    end
  endtask

  initial begin
    in_item_t hdr;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Data ahead of any header runs on the cleared registers.
    send_item(data_item(8'h00, 1'b0));
    send_item(data_item(8'hFF, 1'b1));
    hdr = '0;
    send_frame(hdr, 3, PICK_FIRST);
    send_item(data_item(8'hFF, 1'b0));
    hdr = '1;
    send_frame(hdr, 2, PICK_SECOND);
    send_item(data_item(8'h00, 1'b1));
    send_frame(random_item(), 3, PICK_NONE);
    send_frame(random_item(), 0, PICK_NONE);
    send_frame(random_item(), 1, PICK_FIRST);
    drain();

    program_regs(32'h0000_0000, 32'hFFFF_FFFF, 8'h00);
    run_random(60);
    drain();

    program_regs(32'hFFFF_FFFF, 32'h0000_0000, 8'hFF);
    run_random(30);
    calm = 1'b1;
    run_random(80);
    calm = 1'b0;
    drain();

    program_regs($urandom, $urandom, 8'($urandom_range(255)));
    run_random(50);
    drain();
    // Over-length frame: bytes past the limit must vanish.
    send_frame(random_item(), MAX_BYTES + 12, PICK_FIRST);
    run_random(40);
    drain();

    program_regs($urandom, $urandom, 8'($urandom_range(255)));
    run_random(70);
    drain();

    $display("Sent %0d input transfers, checked %0d results under five key settings.",
             items_sent, checked);
    $display("Included headerless data, unknown keys, second-key frames and frame overflow.");
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results never seen", mismatches, pending);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/lfd_pkg.sv
src/lfd_front.sv
src/lfd_cmd_fifo.sv
src/lfd_back.sv
src/lfsr_frame_descrambler_core.sv
tb/lfd_descrambler_checker.sv
tb/tb_lfsr_frame_descrambler_core.sv
